@@ rtl/z80s_pkg.sv @@
// Shared types, constants and flag helpers for the Z80-style instruction step block.
// Used by z80s_alu and z80_subset_instruction_step; depends on nothing else.
package z80s_pkg;

    // Memory geometry.
    localparam int ADDR_BITS = 16;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    // Operation selector carried in the input word's tuser.
    typedef enum logic [1:0] {
        OPER_WRITE = 2'd0,
        OPER_READ  = 2'd1,
        OPER_EXEC  = 2'd2,
        OPER_SETPC = 2'd3
    } oper_t;

    // Implemented opcodes.
    localparam logic [7:0] OPC_LD_BC_NN = 8'h01;
    localparam logic [7:0] OPC_LD_MBC_A = 8'h02;
    localparam logic [7:0] OPC_INC_BC   = 8'h03;
    localparam logic [7:0] OPC_INC_B    = 8'h04;
    localparam logic [7:0] OPC_DEC_B    = 8'h05;
    localparam logic [7:0] OPC_LD_B_N   = 8'h06;
    localparam logic [7:0] OPC_RLCA     = 8'h07;
    localparam logic [7:0] OPC_EX_AF    = 8'h08;
    localparam logic [7:0] OPC_ADD_HL   = 8'h09;
    localparam logic [7:0] OPC_LD_A_MBC = 8'h0a;
    localparam logic [7:0] OPC_DEC_BC   = 8'h0b;
    localparam logic [7:0] OPC_INC_C    = 8'h0c;
    localparam logic [7:0] OPC_DEC_C    = 8'h0d;
    localparam logic [7:0] OPC_INC_DE   = 8'h13;
    localparam logic [7:0] OPC_DEC_DE   = 8'h1b;
    localparam logic [7:0] OPC_INC_HL   = 8'h23;
    localparam logic [7:0] OPC_DEC_HL   = 8'h2b;
    localparam logic [7:0] OPC_INC_SP   = 8'h33;
    localparam logic [7:0] OPC_DEC_SP   = 8'h3b;
    localparam logic [7:0] OPC_HALT     = 8'h76;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WR,
        ST_RD,
        ST_RDW,
        ST_FETCH,
        ST_DECODE,
        ST_OPND,
        ST_OPLO,
        ST_OPHI,
        ST_DWR,
        ST_DRD,
        ST_DRDW,
        ST_EXEC,
        ST_DONE
    } state_t;

    // Shared adder request and result.
    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [15:0] sum;
        logic        half;
        logic        carry;
    } alu_res_t;

    // Flags after an 8-bit increment: S, 5, 3 from the result, Z, H on low nibble zero,
    // P/V on 0x80, N clear. Carry is merged in by the caller.
    function automatic logic [7:0] inc_flags(input logic [7:0] r);
        logic [7:0] f;
        f    = r & 8'ha8;
        f[6] = (r == 8'h00);
        f[4] = (r[3:0] == 4'h0);
        f[2] = (r == 8'h80);
        return f;
    endfunction

    // Flags after an 8-bit decrement: H on low nibble 0xF, P/V on 0x7F, N set.
    function automatic logic [7:0] dec_flags(input logic [7:0] r);
        logic [7:0] f;
        f    = r & 8'ha8;
        f[6] = (r == 8'h00);
        f[4] = (r[3:0] == 4'hf);
        f[2] = (r == 8'h7f);
        f[1] = 1'b1;
        return f;
    endfunction

    // RLCA on the whole AF word: rotate A, carry takes old bit 7, keep S, Z and P/V.
    function automatic logic [15:0] rlca_af(input logic [15:0] af);
        return ((af >> 7) & 16'h0128) | ((af << 1) & 16'hfe00) |
               (af & 16'h00c4) | {15'b0, af[15]};
    endfunction

endpackage

@@ rtl/z80s_alu.sv @@
// Shared 16-bit adder of the instruction step block, with half and full carry.
// Depends on z80s_pkg for the request and result types.
module z80s_alu import z80s_pkg::*; (
    input  alu_req_t req,
    output alu_res_t res
);

    logic [16:0] sum_w;
    logic [16:0] xor_w;

    // One add serves increments, decrements (by adding all ones) and ADD HL,BC.
    assign sum_w = {1'b0, req.a} + {1'b0, req.b};
    assign xor_w = {1'b0, req.a} ^ {1'b0, req.b} ^ sum_w;

    assign res.sum   = sum_w[15:0];
    assign res.half  = xor_w[12];
    assign res.carry = sum_w[16];

endmodule

@@ rtl/z80_subset_instruction_step.sv @@
// Top level of the Z80-style instruction step block: sequencer, registers, byte memory.
// Depends on z80s_pkg and instantiates z80s_alu.
// Paths from accept to result valid, set by the single memory port and shared adder:
// set PC straight to DONE; write WR; read RD, RDW; execute FETCH, DECODE, then EXEC (plain), DWR
// (LD (BC),A), OPND, OPLO (LD B,n), DRD, DRDW (LD A,(BC)) or OPND, OPLO, OPHI (LD BC,nn),
// each then DONE. One word is in flight at a time; the next word is taken as soon as the
// sequencer is back in idle, while the previous result may still wait.
// Reset clears all CPU registers and the handshake state; memory holds no reset value.
module z80_subset_instruction_step import z80s_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata: [15:0] mem_address, [23:16] mem_data
    input  logic [23:0]  s_tdata,
    // s_tuser: [1:0] operation
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: [7:0] read_data, [15:8] opcode, [31:16] reg_pc, [47:32] reg_last_pc,
    // [63:48] reg_af, [79:64] reg_bc, [95:80] reg_de, [111:96] reg_hl,
    // [127:112] reg_sp, [128] halted, [135:129] zero
    output logic [135:0] m_tdata
);

    state_t state_reg, state_next;

    // Latched input word.
    oper_t       oper_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;

    // CPU registers.
    logic [15:0] af_reg, af_alt_reg, bc_reg, de_reg, hl_reg, sp_reg, pc_reg, last_pc_reg;
    logic [7:0]  rd_reg;
    logic [7:0]  opc_reg;
    logic        halted_reg;

    // Output register.
    logic         m_valid_reg;
    logic [135:0] m_data_reg;

    // Memory port.
    logic [7:0]  mem [MEM_DEPTH];
    logic [15:0] mem_addr;
    logic        mem_we;
    logic [7:0]  mem_wdata;
    logic [7:0]  mem_rdata_reg;

    // Shared adder.
    alu_req_t alu_req;
    alu_res_t alu_res;

    logic accept;
    logic out_free;
    logic load_out;

    z80s_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (oper_t'(s_tuser))
                        OPER_WRITE: state_next = ST_WR;
                        OPER_READ:  state_next = ST_RD;
                        OPER_EXEC:  state_next = ST_FETCH;
                        OPER_SETPC: state_next = ST_DONE;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_WR:     state_next = ST_DONE;
            ST_RD:     state_next = ST_RDW;
            ST_RDW:    state_next = ST_DONE;
            ST_FETCH:  state_next = ST_DECODE;
            ST_DECODE: begin
                unique case (mem_rdata_reg)
                    OPC_LD_BC_NN, OPC_LD_B_N: state_next = ST_OPND;
                    OPC_LD_MBC_A:             state_next = ST_DWR;
                    OPC_LD_A_MBC:             state_next = ST_DRD;
                    default:                  state_next = ST_EXEC;
                endcase
            end
            ST_OPND:   state_next = ST_OPLO;
            ST_OPLO:   state_next = (opc_reg == OPC_LD_BC_NN) ? ST_OPHI : ST_DONE;
            ST_OPHI:   state_next = ST_DONE;
            ST_DWR:    state_next = ST_DONE;
            ST_DRD:    state_next = ST_DRDW;
            ST_DRDW:   state_next = ST_DONE;
            ST_EXEC:   state_next = ST_DONE;
            ST_DONE:   state_next = out_free ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Memory port, adder operands and handshake per state.
    always_comb begin
        s_tready  = 1'b0;
        load_out  = 1'b0;
        mem_addr  = pc_reg;
        mem_we    = 1'b0;
        mem_wdata = data_reg;
        alu_req.a = pc_reg;
        alu_req.b = 16'h0001;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_WR: begin
                mem_addr = addr_reg;
                mem_we   = 1'b1;
            end
            ST_RD:   mem_addr = addr_reg;
            ST_OPLO: mem_addr = pc_reg;
            ST_DWR: begin
                mem_addr  = bc_reg;
                mem_we    = 1'b1;
                mem_wdata = af_reg[15:8];
            end
            ST_DRD:  mem_addr = bc_reg;
            ST_EXEC: begin
                unique case (opc_reg)
                    OPC_INC_BC: begin alu_req.a = bc_reg; alu_req.b = 16'h0001; end
                    OPC_DEC_BC: begin alu_req.a = bc_reg; alu_req.b = 16'hffff; end
                    OPC_INC_B:  begin alu_req.a = bc_reg; alu_req.b = 16'h0100; end
                    OPC_DEC_B:  begin alu_req.a = bc_reg; alu_req.b = 16'hff00; end
                    OPC_INC_C: begin
                        alu_req.a = {8'h00, bc_reg[7:0]};
                        alu_req.b = 16'h0001;
                    end
                    OPC_DEC_C: begin
                        alu_req.a = {8'h00, bc_reg[7:0]};
                        alu_req.b = 16'hffff;
                    end
                    OPC_ADD_HL: begin alu_req.a = hl_reg; alu_req.b = bc_reg; end
                    OPC_INC_DE: begin alu_req.a = de_reg; alu_req.b = 16'h0001; end
                    OPC_DEC_DE: begin alu_req.a = de_reg; alu_req.b = 16'hffff; end
                    OPC_INC_HL: begin alu_req.a = hl_reg; alu_req.b = 16'h0001; end
                    OPC_DEC_HL: begin alu_req.a = hl_reg; alu_req.b = 16'hffff; end
                    OPC_INC_SP: begin alu_req.a = sp_reg; alu_req.b = 16'h0001; end
                    OPC_DEC_SP: begin alu_req.a = sp_reg; alu_req.b = 16'hffff; end
                    OPC_HALT:   begin alu_req.a = pc_reg; alu_req.b = 16'hffff; end
                    default:    begin alu_req.a = pc_reg; alu_req.b = 16'h0000; end
                endcase
            end
            ST_DONE: load_out = out_free;
            default: begin
            end
        endcase
    end

    // Single-port byte memory with registered read data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr[ADDR_BITS-1:0]] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_addr[ADDR_BITS-1:0]];
    end

    // Sequencer and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Input word latch, per-word result fields and the output word.
    always_ff @(posedge aclk) begin
        if (accept) begin
            oper_reg   <= oper_t'(s_tuser);
            addr_reg   <= s_tdata[15:0];
            data_reg   <= s_tdata[23:16];
            rd_reg     <= 8'h00;
            opc_reg    <= 8'h00;
            halted_reg <= 1'b0;
        end
        if (state_reg == ST_RDW) begin
            rd_reg <= mem_rdata_reg;
        end
        if (state_reg == ST_DECODE) begin
            opc_reg <= mem_rdata_reg;
        end
        if (state_reg == ST_EXEC && opc_reg == OPC_HALT) begin
            halted_reg <= 1'b1;
        end
        if (load_out) begin
            m_data_reg <= {7'b0, halted_reg, sp_reg, hl_reg, de_reg, bc_reg, af_reg,
                           last_pc_reg, pc_reg, opc_reg, rd_reg};
        end
    end

    // CPU register updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            af_reg      <= 16'h0000;
            af_alt_reg  <= 16'h0000;
            bc_reg      <= 16'h0000;
            de_reg      <= 16'h0000;
            hl_reg      <= 16'h0000;
            sp_reg      <= 16'h0000;
            pc_reg      <= 16'h0000;
            last_pc_reg <= 16'h0000;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && oper_t'(s_tuser) == OPER_SETPC) begin
                        pc_reg <= 16'h0000;
                    end
                end
                ST_FETCH:  last_pc_reg <= pc_reg;
                // Step past the opcode, and past each operand byte as it is requested.
                ST_DECODE: pc_reg <= alu_res.sum;
                ST_OPND:   pc_reg <= alu_res.sum;
                ST_OPLO: begin
                    if (opc_reg == OPC_LD_BC_NN) begin
                        bc_reg[7:0] <= mem_rdata_reg;
                        pc_reg      <= alu_res.sum;
                    end else begin
                        bc_reg[15:8] <= mem_rdata_reg;
                    end
                end
                ST_OPHI:   bc_reg[15:8] <= mem_rdata_reg;
                ST_DRDW:   af_reg[15:8] <= mem_rdata_reg;
                ST_EXEC: begin
                    unique case (opc_reg)
                        OPC_INC_BC, OPC_DEC_BC: bc_reg <= alu_res.sum;
                        OPC_INC_B: begin
                            bc_reg <= alu_res.sum;
                            af_reg <= {af_reg[15:8],
                                       inc_flags(alu_res.sum[15:8]) | {7'b0, af_reg[0]}};
                        end
                        OPC_DEC_B: begin
                            bc_reg <= alu_res.sum;
                            af_reg <= {af_reg[15:8],
                                       dec_flags(alu_res.sum[15:8]) | {7'b0, af_reg[0]}};
                        end
                        OPC_INC_C: begin
                            bc_reg[7:0] <= alu_res.sum[7:0];
                            af_reg <= {af_reg[15:8],
                                       inc_flags(alu_res.sum[7:0]) | {7'b0, af_reg[0]}};
                        end
                        OPC_DEC_C: begin
                            bc_reg[7:0] <= alu_res.sum[7:0];
                            af_reg <= {af_reg[15:8],
                                       dec_flags(alu_res.sum[7:0]) | {7'b0, af_reg[0]}};
                        end
                        OPC_RLCA: af_reg <= rlca_af(af_reg);
                        OPC_EX_AF: begin
                            af_reg     <= af_alt_reg;
                            af_alt_reg <= af_reg;
                        end
                        // ADD HL,BC: 5 and 3 from the sum's high byte, H and C from carries.
                        OPC_ADD_HL: begin
                            hl_reg <= alu_res.sum;
                            af_reg <= (af_reg & ~16'h003b) |
                                      {10'b0, alu_res.sum[13], alu_res.half,
                                       alu_res.sum[11], 2'b00, alu_res.carry};
                        end
                        OPC_INC_DE, OPC_DEC_DE: de_reg <= alu_res.sum;
                        OPC_INC_HL, OPC_DEC_HL: hl_reg <= alu_res.sum;
                        OPC_INC_SP, OPC_DEC_SP: sp_reg <= alu_res.sum;
                        // HALT steps back onto its own opcode.
                        OPC_HALT: pc_reg <= alu_res.sum;
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // A new word is never taken in the cycle after one was accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input accepted while a word was in flight");

    // Memory writes come only from the write operation or LD (BC),A.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_WR || state_reg == ST_DWR))
        else $error("memory write outside a write state");

    // A halted result always carries the HALT opcode.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[128]) |-> (m_data_reg[15:8] == OPC_HALT))
        else $error("halted flag without HALT opcode");

    // Read data and opcode are never both present in one result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[7:0] != 8'h00) |-> (m_data_reg[15:8] == 8'h00))
        else $error("read data and opcode both set");

    // The latched operation matches the path the sequencer takes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |-> (oper_reg == OPER_EXEC))
        else $error("instruction fetch without an execute operation");

endmodule

@@ verif/z80s_state_checker.sv @@
// Checker for the Z80-style instruction step block: watches both stream channels,
// keeps its own copy of the CPU registers and memory, and compares every result word.
// Depends on z80s_pkg for the operation enum, the opcode names and the address width.
module z80s_state_checker import z80s_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // s_tdata: [15:0] mem_address, [23:16] mem_data
    input  logic [23:0]  s_tdata,
    // s_tuser: [1:0] operation
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: [7:0] read_data, [15:8] opcode, [31:16] reg_pc, [47:32] reg_last_pc,
    // [63:48] reg_af, [79:64] reg_bc, [95:80] reg_de, [111:96] reg_hl,
    // [127:112] reg_sp, [128] halted
    input  logic [135:0] m_tdata,
    output int           mismatches,
    output int           awaited,
    output int           checked
);

    // Everything the block reports after one operation.
    typedef struct {
        logic [7:0]  read_data;
        logic [7:0]  opcode;
        logic [15:0] pc;
        logic [15:0] last_pc;
        logic [15:0] af;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic [15:0] sp;
        logic        halted;
    } cpu_view_t;

    // Our own copy of the CPU state.
    logic [7:0]  ram [0:MEM_DEPTH-1];
    logic [15:0] af, af_alt, bc, de, hl, sp, pc, last_pc;
    cpu_view_t   expected_views [$];

    initial begin
        mismatches = 0;
        awaited    = 0;
        checked    = 0;
    end

    // Only the low ADDR_BITS of an address select a byte.
    function automatic logic [ADDR_BITS-1:0] slot(input logic [15:0] a);
        return a[ADDR_BITS-1:0];
    endfunction

    // Flags of an 8-bit increment or decrement, carry position left at zero.
    // Half carry and overflow mark the boundary that the result just crossed.
    function automatic logic [7:0] incdec_flags(input logic [7:0] r, input logic down);
        logic h, v;
        h = down ? (r[3:0] == 4'hf) : (r[3:0] == 4'h0);
        v = down ? (r == 8'h7f) : (r == 8'h80);
        return {r[7], r == 8'h00, r[5], h, r[3], v, down, 1'b0};
    endfunction

    // Apply one operation to the state and return what the block should report.
    task automatic advance_cpu(input oper_t op, input logic [15:0] addr,
                               input logic [7:0] data, output cpu_view_t v);
        logic [7:0]  code, rd, f;
        logic [15:0] next_pc;
        logic [16:0] wide_sum, carries;
        logic        is_halt;
        code    = 8'h00;
        rd      = 8'h00;
        is_halt = 1'b0;
        case (op)
            OPER_WRITE: ram[slot(addr)] = data;
            OPER_READ:  rd = ram[slot(addr)];
            OPER_SETPC: pc = 16'h0000;
            OPER_EXEC: begin
                last_pc = pc;
                code    = ram[slot(pc)];
                next_pc = pc + 16'd1;
                case (code)
                    OPC_LD_BC_NN: begin
                        bc      = {ram[slot(next_pc + 16'd1)], ram[slot(next_pc)]};
                        next_pc = next_pc + 16'd2;
                    end
                    OPC_LD_MBC_A: ram[slot(bc)] = af[15:8];
                    OPC_INC_BC:   bc = bc + 16'd1;
                    OPC_DEC_BC:   bc = bc - 16'd1;
                    OPC_INC_B: begin
                        bc[15:8] = bc[15:8] + 8'd1;
                        f        = incdec_flags(bc[15:8], 1'b0);
                        af[7:1]  = f[7:1];
                    end
                    OPC_DEC_B: begin
                        bc[15:8] = bc[15:8] - 8'd1;
                        f        = incdec_flags(bc[15:8], 1'b1);
                        af[7:1]  = f[7:1];
                    end
                    OPC_INC_C: begin
                        bc[7:0] = bc[7:0] + 8'd1;
                        f       = incdec_flags(bc[7:0], 1'b0);
                        af[7:1] = f[7:1];
                    end
                    OPC_DEC_C: begin
                        bc[7:0] = bc[7:0] - 8'd1;
                        f       = incdec_flags(bc[7:0], 1'b1);
                        af[7:1] = f[7:1];
                    end
                    OPC_LD_B_N: begin
                        bc[15:8] = ram[slot(next_pc)];
                        next_pc  = next_pc + 16'd1;
                    end
                    // Rotate A left; carry gets the old top bit, bits 5 and 3 follow new A.
                    OPC_RLCA: af = {af[14:8], af[15], af[7:6], af[12], 1'b0,
                                    af[10], af[2], 1'b0, af[15]};
                    OPC_EX_AF: {af, af_alt} = {af_alt, af};
                    // 16-bit add: half carry out of bit 11, carry out of bit 15.
                    OPC_ADD_HL: begin
                        wide_sum = {1'b0, hl} + {1'b0, bc};
                        carries  = wide_sum ^ {1'b0, hl} ^ {1'b0, bc};
                        af[7:0]  = {af[7:6], wide_sum[13], carries[12], wide_sum[11],
                                    af[2], 1'b0, wide_sum[16]};
                        hl       = wide_sum[15:0];
                    end
                    OPC_LD_A_MBC: af[15:8] = ram[slot(bc)];
                    OPC_INC_DE:   de = de + 16'd1;
                    OPC_DEC_DE:   de = de - 16'd1;
                    OPC_INC_HL:   hl = hl + 16'd1;
                    OPC_DEC_HL:   hl = hl - 16'd1;
                    OPC_INC_SP:   sp = sp + 16'd1;
                    OPC_DEC_SP:   sp = sp - 16'd1;
                    // HALT leaves PC on itself so it runs again.
                    OPC_HALT: begin
                        next_pc = pc;
                        is_halt = 1'b1;
                    end
                    default: ;
                endcase
                pc = next_pc;
            end
        endcase
        v.read_data = rd;
        v.opcode    = code;
        v.pc        = pc;
        v.last_pc   = last_pc;
        v.af        = af;
        v.bc        = bc;
        v.de        = de;
        v.hl        = hl;
        v.sp        = sp;
        v.halted    = is_halt;
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Result words are matched first, so a word can never be paired with the
    // input word taken at the same edge.
    always @(posedge aclk) begin : watch
        cpu_view_t want, predicted;
        if (!aresetn) begin
            {af, af_alt, bc, de, hl, sp, pc, last_pc} = '0;
            expected_views.delete();
            awaited = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_views.size() == 0) begin
                    $error("result word arrived with no expected result waiting");
                    mismatches++;
                end else begin
                    want = expected_views.pop_front();
                    compare_field("read_data", {8'h00, want.read_data},
                                  {8'h00, m_tdata[7:0]});
                    compare_field("opcode", {8'h00, want.opcode}, {8'h00, m_tdata[15:8]});
                    compare_field("reg_pc", want.pc, m_tdata[31:16]);
                    compare_field("reg_last_pc", want.last_pc, m_tdata[47:32]);
                    compare_field("reg_af", want.af, m_tdata[63:48]);
                    compare_field("reg_bc", want.bc, m_tdata[79:64]);
                    compare_field("reg_de", want.de, m_tdata[95:80]);
                    compare_field("reg_hl", want.hl, m_tdata[111:96]);
                    compare_field("reg_sp", want.sp, m_tdata[127:112]);
                    compare_field("halted", {15'b0, want.halted}, {15'b0, m_tdata[128]});
                    checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                advance_cpu(oper_t'(s_tuser), s_tdata[15:0], s_tdata[23:16], predicted);
                expected_views.push_back(predicted);
            end
            awaited = expected_views.size();
        end
    end

endmodule

@@ verif/z80_subset_instruction_step_tb.sv @@
// Testbench top for the Z80-style instruction step block: clock, reset, stimulus and verdict.
// Stimulus keeps a light shadow of PC, BC, A and memory so no unwritten byte is ever read.
// Depends on z80s_pkg, the block itself and z80s_state_checker.
module z80_subset_instruction_step_tb import z80s_pkg::*;;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_WORDS = 950;
    localparam int LONG_HOLD    = 300;
    localparam logic [7:0] OPC_NOP          = 8'h00;
    localparam logic [7:0] OPC_UNDEFINED_ED = 8'hed;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata  = '0;
    logic [1:0]   s_tuser  = OPER_WRITE;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;

    int mismatches, awaited, checked;
    int cycle_count = 0;
    int words_sent  = 0;
    int halts_run   = 0;
    int per_oper [4] = '{0, 0, 0, 0};
    bit no_idle      = 1'b0;
    bit hold_request = 1'b0;

    // Shadow of the parts of the CPU that decide which bytes an instruction touches.
    logic [7:0]  img [0:65535];
    bit          known [0:65535];
    logic [15:0] written_list [$];
    logic [15:0] at_pc   = '0;
    logic [15:0] at_bc   = '0;
    logic [7:0]  acc     = '0;
    logic [7:0]  acc_alt = '0;

    logic [7:0] opcode_menu [0:19] = '{
        OPC_LD_BC_NN, OPC_LD_MBC_A, OPC_INC_BC, OPC_INC_B, OPC_DEC_B,
        OPC_LD_B_N, OPC_RLCA, OPC_EX_AF, OPC_ADD_HL, OPC_LD_A_MBC,
        OPC_DEC_BC, OPC_INC_C, OPC_DEC_C, OPC_INC_DE, OPC_DEC_DE,
        OPC_INC_HL, OPC_DEC_HL, OPC_INC_SP, OPC_DEC_SP, OPC_HALT};
    logic [7:0] corner_bytes [0:6] = '{8'h00, 8'h7f, 8'h80, 8'hff, 8'h0f, 8'hf0, 8'h10};

    z80_subset_instruction_step dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    z80s_state_checker state_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .awaited    (awaited),
        .checked    (checked)
    );

    always #2 aclk = ~aclk;

    // Hard stop in case the block hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, awaited);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [7:0] pick_opcode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return OPC_NOP;
        if (r < 90) return opcode_menu[$urandom_range(0, 19)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_operand();
        if ($urandom_range(0, 2) == 0) return corner_bytes[$urandom_range(0, 6)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int operand_bytes(input logic [7:0] opc);
        if (opc == OPC_LD_BC_NN) return 2;
        if (opc == OPC_LD_B_N) return 1;
        return 0;
    endfunction

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input oper_t op, input logic [15:0] addr, input logic [7:0] data);
        int gap;
        gap = no_idle ? 0 : gap_length();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {data, addr};
        do @(posedge aclk); while (!s_tready);
        per_oper[int'(op)]++;
        words_sent++;
    endtask

    task automatic note_byte(input logic [15:0] a, input logic [7:0] d);
        img[a] = d;
        if (!known[a]) begin
            known[a] = 1'b1;
            written_list.push_back(a);
        end
    endtask

    task automatic put_byte(input logic [15:0] a, input logic [7:0] d);
        send_word(OPER_WRITE, a, d);
        note_byte(a, d);
    endtask

    task automatic peek_byte(input logic [15:0] a);
        send_word(OPER_READ, a, 8'($urandom));
    endtask

    task automatic restart();
        send_word(OPER_SETPC, 16'($urandom), 8'($urandom));
        at_pc = 16'h0000;
    endtask

    // Execute one instruction, first writing any byte it would read that is still unset.
    task automatic step_cpu();
        logic [7:0] opc;
        int extra;
        if (!known[at_pc]) put_byte(at_pc, pick_opcode());
        opc   = img[at_pc];
        extra = operand_bytes(opc);
        for (int i = 1; i <= extra; i++) begin
            if (!known[at_pc + 16'(i)]) put_byte(at_pc + 16'(i), pick_operand());
        end
        if (opc == OPC_LD_A_MBC && !known[at_bc]) put_byte(at_bc, 8'($urandom));
        send_word(OPER_EXEC, 16'($urandom), 8'($urandom));
        case (opc)
            OPC_LD_BC_NN: at_bc = {img[at_pc + 16'd2], img[at_pc + 16'd1]};
            OPC_LD_B_N:   at_bc[15:8] = img[at_pc + 16'd1];
            OPC_LD_MBC_A: note_byte(at_bc, acc);
            OPC_INC_BC:   at_bc = at_bc + 16'd1;
            OPC_DEC_BC:   at_bc = at_bc - 16'd1;
            OPC_INC_B:    at_bc[15:8] = at_bc[15:8] + 8'd1;
            OPC_DEC_B:    at_bc[15:8] = at_bc[15:8] - 8'd1;
            OPC_INC_C:    at_bc[7:0] = at_bc[7:0] + 8'd1;
            OPC_DEC_C:    at_bc[7:0] = at_bc[7:0] - 8'd1;
            OPC_RLCA:     acc = {acc[6:0], acc[7]};
            OPC_EX_AF:    {acc, acc_alt} = {acc_alt, acc};
            OPC_LD_A_MBC: acc = img[at_bc];
            OPC_HALT:     halts_run++;
            default: ;
        endcase
        if (opc != OPC_HALT) at_pc = at_pc + 16'(1 + extra);
    endtask

    // Receiver: random stalls, plus one long hold-off when the stimulus asks for it.
    initial begin
        int stall_left, hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0) stall_left = 1 + gap_length();
            end
        end
    end

    // Stimulus: a directed opening, then random programs, free runs and memory traffic.
    initial begin
        int kind, len;
        bit hold_done;
        logic [15:0] wa;
        logic [7:0] opc;
        hold_done = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Address and data extremes, an unknown opcode, flag corners and a repeating HALT.
        put_byte(16'hffff, 8'hff);
        peek_byte(16'hffff);
        put_byte(16'h8000, 8'h00);
        put_byte(16'h0000, OPC_DEC_DE);
        put_byte(16'h0001, OPC_UNDEFINED_ED);
        put_byte(16'h0002, OPC_LD_BC_NN);
        put_byte(16'h0003, 8'hff);
        put_byte(16'h0004, 8'h7f);
        put_byte(16'h0005, OPC_INC_B);
        put_byte(16'h0006, OPC_INC_C);
        put_byte(16'h0007, OPC_HALT);
        repeat (7) step_cpu();
        restart();
        step_cpu();
        peek_byte(16'h0000);

        while (words_sent < RANDOM_WORDS + 22) begin
            kind    = $urandom_range(0, 99);
            no_idle = ($urandom_range(0, 9) == 0);
            // Once, keep offering words while the receiver holds off for a long time.
            if (!hold_done && words_sent > 350) begin
                hold_done    = 1'b1;
                no_idle      = 1'b1;
                hold_request = 1'b1;
            end
            if (kind < 55) begin
                // Load a short program at address zero, restart and run it.
                len = $urandom_range(2, 14);
                wa  = 16'h0000;
                repeat (len) begin
                    opc = pick_opcode();
                    put_byte(wa, opc);
                    wa = wa + 16'd1;
                    repeat (operand_bytes(opc)) begin
                        put_byte(wa, pick_operand());
                        wa = wa + 16'd1;
                    end
                end
                restart();
                repeat ($urandom_range(len, len + 6)) step_cpu();
            end else if (kind < 75) begin
                repeat ($urandom_range(4, 24)) step_cpu();
            end else begin
                repeat ($urandom_range(2, 10)) begin
                    case ($urandom_range(0, 3))
                        0: put_byte(16'($urandom), 8'($urandom));
                        1: peek_byte(written_list[$urandom_range(0, written_list.size() - 1)]);
                        2: step_cpu();
                        default: restart();
                    endcase
                end
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (awaited != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);

        $display("Sent %0d words: %0d writes, %0d reads, %0d executes, %0d PC resets.",
                 words_sent, per_oper[OPER_WRITE], per_oper[OPER_READ],
                 per_oper[OPER_EXEC], per_oper[OPER_SETPC]);
        $display("Checked %0d results, %0d of them HALT steps, in %0d cycles.",
                 checked, halts_run, cycle_count);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
